@@ src/rfhp_pkg.sv @@
package rfhp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_LEN   = 4'd1,
    PH_SIG   = 4'd2,
    PH_SRC   = 4'd3,
    PH_DST   = 4'd4,
    PH_COUNT = 4'd5,
    PH_ENTRY = 4'd6,
    PH_BODY  = 4'd7,
    PH_DONE  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_ADDRESSING = 3'd0,
    KIND_ENTRY      = 3'd1,
    KIND_BODY_LEN   = 3'd2,
    KIND_BAD_SIG    = 3'd3,
    KIND_SHORT_LEN  = 3'd4
  } kind_e;

  localparam logic [31:0] MIN_FRAME_LENGTH = 32'd17;
  localparam logic [2:0]  SIG_LEN          = 3'd7;
  localparam logic [2:0]  COUNT_LEN        = 3'd2;
  localparam logic [2:0]  ENTRY_LEN        = 3'd6;
  localparam logic [2:0]  ADDR_LAST        = 3'd3;
  localparam logic [2:0]  BODY_LEN         = 3'd4;

  // Result item carried from the parser to the output buffer
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [15:0] entry_total;
    logic [31:0] entry_address;
    logic [15:0] entry_handle;
    logic [31:0] body_length;
    logic [31:0] frame_length;
  } res_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h52;
      3'd1:    r = 8'h4f;
      3'd2:    r = 8'h55;
      3'd3:    r = 8'h54;
      3'd4:    r = 8'h49;
      3'd5:    r = 8'h0d;
      3'd6:    r = 8'h0a;
      default: r = 8'h52;
    endcase
    return r;
  endfunction

  // Place a byte into a little-endian word at lane pos[1:0]
  function automatic logic [31:0] lane(input logic [7:0] b, input logic [2:0] pos);
    return {24'd0, b} << {pos[1:0], 3'b000};
  endfunction

endpackage

@@ src/route_frame_header_parser_top.sv @@
// A result is registered in the output buffer before it reaches the output port.
// Throughput: one frame byte per cycle unless in_stall_o is high; one parser pass per byte.
// A two-entry output buffer decouples the sides; in_stall_o rises only while both are occupied.
// Reset (rst_ni low, asynchronous): parser idles awaiting a start byte, buffer empties.
module route_frame_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel: one frame byte per request
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_start_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  source_node_o,
  output logic [7:0]  dest_node_o,
  output logic [15:0] entry_total_o,
  output logic [31:0] entry_address_o,
  output logic [15:0] entry_handle_o,
  output logic [31:0] body_length_o,
  output logic [31:0] frame_length_o
);

  logic           step;
  logic           res_valid;
  logic           buf_full;
  rfhp_pkg::res_t res;
  rfhp_pkg::res_t head;

  // A request is taken whenever the buffer has a free slot; each byte
  // yields at most one result, so one slot is always enough.
  assign in_stall_o = buf_full;
  assign step       = in_valid_i && !buf_full;

  rfhp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (frame_byte_i),
    .start_i     (frame_start_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rfhp_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_res_i (res),
    .full_o     (buf_full),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .head_o     (head)
  );

  // Unpack the head entry onto the result ports
  assign result_kind_o   = head.kind;
  assign source_node_o   = head.source_node;
  assign dest_node_o     = head.dest_node;
  assign entry_total_o   = head.entry_total;
  assign entry_address_o = head.entry_address;
  assign entry_handle_o  = head.entry_handle;
  assign body_length_o   = head.body_length;
  assign frame_length_o  = head.frame_length;

endmodule

@@ src/rfhp_parse.sv @@
module rfhp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          start_i,
  output logic          res_valid_o,
  output rfhp_pkg::res_t res_o
);

  rfhp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [2:0]  lsize_q, lsize_d;
  logic [31:0] gather_q, gather_d;
  logic [31:0] dlen_q, dlen_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  dst_q, dst_d;
  logic [15:0] total_q, total_d;
  logic [15:0] left_q, left_d;
  logic [31:0] addr_q, addr_d;

  logic [31:0] gathered;
  logic [2:0]  pos_inc;

  assign gathered = gather_q | rfhp_pkg::lane(byte_i, pos_q);
  assign pos_inc  = pos_q + 3'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    lsize_d  = lsize_q;
    gather_d = gather_q;
    dlen_d   = dlen_q;
    src_d    = src_q;
    dst_d    = dst_q;
    total_d  = total_q;
    left_d   = left_q;
    addr_d   = addr_q;
    res_valid_o = 1'b0;
    res_o.kind          = rfhp_pkg::KIND_ADDRESSING;
    res_o.entry_address = '0;
    res_o.entry_handle  = '0;
    res_o.body_length   = '0;
    if (start_i) begin
      lsize_d  = {1'b0, byte_i[1:0]} + 3'd1;
      pos_d    = '0;
      gather_d = '0;
      dlen_d   = '0;
      src_d    = '0;
      dst_d    = '0;
      total_d  = '0;
      left_d   = '0;
      addr_d   = '0;
      phase_d  = rfhp_pkg::PH_LEN;
    end else begin
      unique case (phase_q)
        rfhp_pkg::PH_LEN: begin
          dlen_d = dlen_q | rfhp_pkg::lane(byte_i, pos_q);
          pos_d  = pos_inc;
          if (pos_inc >= lsize_q) begin
            pos_d = '0;
            if (dlen_d < rfhp_pkg::MIN_FRAME_LENGTH) begin
              phase_d     = rfhp_pkg::PH_DONE;
              res_valid_o = 1'b1;
              res_o.kind  = rfhp_pkg::KIND_SHORT_LEN;
            end else begin
              phase_d = rfhp_pkg::PH_SIG;
            end
          end
        end
        rfhp_pkg::PH_SIG: begin
          if (byte_i != rfhp_pkg::sig_byte(pos_q)) begin
            phase_d     = rfhp_pkg::PH_DONE;
            pos_d       = '0;
            res_valid_o = 1'b1;
            res_o.kind  = rfhp_pkg::KIND_BAD_SIG;
          end else if (pos_inc >= rfhp_pkg::SIG_LEN) begin
            pos_d   = '0;
            phase_d = rfhp_pkg::PH_SRC;
          end else begin
            pos_d = pos_inc;
          end
        end
        rfhp_pkg::PH_SRC: begin
          src_d   = byte_i;
          phase_d = rfhp_pkg::PH_DST;
        end
        rfhp_pkg::PH_DST: begin
          dst_d    = byte_i;
          phase_d  = rfhp_pkg::PH_COUNT;
          pos_d    = '0;
          gather_d = '0;
        end
        rfhp_pkg::PH_COUNT: begin
          gather_d = gathered;
          pos_d    = pos_inc;
          if (pos_inc >= rfhp_pkg::COUNT_LEN) begin
            total_d     = gathered[15:0];
            left_d      = gathered[15:0];
            pos_d       = '0;
            gather_d    = '0;
            phase_d     = (gathered[15:0] != 16'd0) ? rfhp_pkg::PH_ENTRY
                                                    : rfhp_pkg::PH_BODY;
            res_valid_o = 1'b1;
            res_o.kind  = rfhp_pkg::KIND_ADDRESSING;
          end
        end
        rfhp_pkg::PH_ENTRY: begin
          gather_d = gathered;
          pos_d    = pos_inc;
          if (pos_q == rfhp_pkg::ADDR_LAST) begin
            addr_d   = gathered;
            gather_d = '0;
          end
          if (pos_inc >= rfhp_pkg::ENTRY_LEN) begin
            pos_d    = '0;
            gather_d = '0;
            left_d   = left_q - 16'd1;
            if (left_d == 16'd0) phase_d = rfhp_pkg::PH_BODY;
            res_valid_o         = 1'b1;
            res_o.kind          = rfhp_pkg::KIND_ENTRY;
            res_o.entry_address = addr_q;
            res_o.entry_handle  = gathered[15:0];
          end
        end
        rfhp_pkg::PH_BODY: begin
          gather_d = gathered;
          pos_d    = pos_inc;
          if (pos_inc >= rfhp_pkg::BODY_LEN) begin
            pos_d             = '0;
            gather_d          = '0;
            phase_d           = rfhp_pkg::PH_DONE;
            res_valid_o       = 1'b1;
            res_o.kind        = rfhp_pkg::KIND_BODY_LEN;
            res_o.body_length = gathered;
          end
        end
        default: begin
        end
      endcase
    end
    res_o.source_node  = src_d;
    res_o.dest_node    = dst_d;
    res_o.entry_total  = total_d;
    res_o.frame_length = dlen_d;
    if (!step_i) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rfhp_pkg::PH_IDLE;
      pos_q    <= '0;
      lsize_q  <= '0;
      gather_q <= '0;
      dlen_q   <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      total_q  <= '0;
      left_q   <= '0;
      addr_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      lsize_q  <= lsize_d;
      gather_q <= gather_d;
      dlen_q   <= dlen_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      total_q  <= total_d;
      left_q   <= left_d;
      addr_q   <= addr_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < rfhp_pkg::SIG_LEN)
    else $error("byte position out of range");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == rfhp_pkg::KIND_BAD_SIG ||
                     res_o.kind == rfhp_pkg::KIND_SHORT_LEN))
    |=> phase_q == rfhp_pkg::PH_DONE)
    else $error("error result without leaving the frame");

  a_entry_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rfhp_pkg::PH_ENTRY |-> left_q != 16'd0)
    else $error("entry phase with no entries left");

endmodule

@@ src/rfhp_outbuf.sv @@
module rfhp_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfhp_pkg::res_t push_res_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           stall_i,
  output rfhp_pkg::res_t head_o
);

  rfhp_pkg::res_t ent0_q, ent0_d, ent1_q, ent1_d;
  logic           vld0_q, vld0_d, vld1_q, vld1_d;
  logic           pop;

  assign pop     = vld0_q && !stall_i;
  assign valid_o = vld0_q;
  assign head_o  = ent0_q;
  assign full_o  = vld1_q;

  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    vld0_d = vld0_q;
    vld1_d = vld1_q;
    if (pop) begin
      ent0_d = ent1_q;
      vld0_d = vld1_q;
      vld1_d = 1'b0;
    end
    if (push_i) begin
      if (!vld0_d) begin
        ent0_d = push_res_i;
        vld0_d = 1'b1;
      end else begin
        ent1_d = push_res_i;
        vld1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else begin
      vld0_q <= vld0_d;
      vld1_q <= vld1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q |-> vld0_q)
    else $error("skid entry held while head empty");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !vld1_q)
    else $error("result pushed into a full buffer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld0_q && stall_i) |=> (vld0_q && ent0_q == $past(ent0_q)))
    else $error("stalled head changed");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // Signature bytes in order of arrival, byte 0 in the low lane.
  localparam logic [55:0] ROUTE_SIG   = 56'h0a0d4954554f52;
  // Cycles with no request and no result moving before the run is declared hung.
  localparam int unsigned STUCK_LIMIT = 2000;

  // One pending request: a frame byte and its start flag.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } link_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  frame_byte;
  logic        frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  result_kind;
  logic [7:0]  source_node;
  logic [7:0]  dest_node;
  logic [15:0] entry_total;
  logic [31:0] entry_address;
  logic [15:0] entry_handle;
  logic [31:0] body_length;
  logic [31:0] frame_length;

  link_byte_t     frame_bytes_q[$];     // requests waiting to be driven
  rfhp_pkg::res_t header_fields_due[$]; // header parts the parser owes us, oldest first
  link_byte_t     next_byte;
  rfhp_pkg::res_t seen_fields;
  rfhp_pkg::res_t want_fields;
  logic        byte_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned live_bytes_queued;
  int unsigned mismatch_count;
  int unsigned stuck_cycles;

  // Our own view of the parser state, updated on every accepted request.
  rfhp_pkg::phase_e hdr_phase   = rfhp_pkg::PH_IDLE;
  logic [2:0]  hdr_pos          = '0;
  logic [2:0]  len_field_bytes  = '0;
  logic [31:0] gathered         = '0;
  logic [31:0] declared_len     = '0;
  logic [7:0]  frame_src        = '0;
  logic [7:0]  frame_dst        = '0;
  logic [15:0] frame_entries    = '0;
  logic [15:0] entries_pending  = '0;
  logic [31:0] entry_addr_held  = '0;

  route_frame_header_parser_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .frame_byte_i    (frame_byte),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_o   (result_kind),
    .source_node_o   (source_node),
    .dest_node_o     (dest_node),
    .entry_total_o   (entry_total),
    .entry_address_o (entry_address),
    .entry_handle_o  (entry_handle),
    .body_length_o   (body_length),
    .frame_length_o  (frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Queue a header part carrying the frame fields gathered so far.
  function automatic void owe_header_part(input rfhp_pkg::kind_e k,
                                          input logic [31:0] addr,
                                          input logic [15:0] handle,
                                          input logic [31:0] body);
    rfhp_pkg::res_t fields;
    fields.kind          = k;
    fields.source_node   = frame_src;
    fields.dest_node     = frame_dst;
    fields.entry_total   = frame_entries;
    fields.entry_address = addr;
    fields.entry_handle  = handle;
    fields.body_length   = body;
    fields.frame_length  = declared_len;
    header_fields_due.push_back(fields);
  endfunction

  // Advance the header walk by one byte; owes at most one header part.
  function automatic void parse_header_byte(input logic [7:0] b, input logic st);
    logic [31:0] placed;
    placed = {24'd0, b} << (8 * hdr_pos[1:0]);
    if (st) begin
      // a start always wins, even in mid-frame
      len_field_bytes = {1'b0, b[1:0]} + 3'd1;
      hdr_pos         = '0;
      gathered        = '0;
      declared_len    = '0;
      frame_src       = '0;
      frame_dst       = '0;
      frame_entries   = '0;
      entries_pending = '0;
      entry_addr_held = '0;
      hdr_phase       = rfhp_pkg::PH_LEN;
    end else begin
      case (hdr_phase)
        rfhp_pkg::PH_LEN: begin
          declared_len = declared_len | placed;
          hdr_pos      = hdr_pos + 3'd1;
          if (hdr_pos >= len_field_bytes) begin
            hdr_pos = '0;
            if (declared_len < rfhp_pkg::MIN_FRAME_LENGTH) begin
              hdr_phase = rfhp_pkg::PH_DONE;
              owe_header_part(rfhp_pkg::KIND_SHORT_LEN, '0, '0, '0);
            end else begin
              hdr_phase = rfhp_pkg::PH_SIG;
            end
          end
        end
        rfhp_pkg::PH_SIG: begin
          if (b != ROUTE_SIG[8 * hdr_pos +: 8]) begin
            hdr_phase = rfhp_pkg::PH_DONE;
            hdr_pos   = '0;
            owe_header_part(rfhp_pkg::KIND_BAD_SIG, '0, '0, '0);
          end else begin
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos >= 3'd7) begin
              hdr_pos   = '0;
              hdr_phase = rfhp_pkg::PH_SRC;
            end
          end
        end
        rfhp_pkg::PH_SRC: begin
          frame_src = b;
          hdr_phase = rfhp_pkg::PH_DST;
        end
        rfhp_pkg::PH_DST: begin
          frame_dst = b;
          hdr_phase = rfhp_pkg::PH_COUNT;
          hdr_pos   = '0;
          gathered  = '0;
        end
        rfhp_pkg::PH_COUNT: begin
          gathered = gathered | placed;
          hdr_pos  = hdr_pos + 3'd1;
          if (hdr_pos >= 3'd2) begin
            frame_entries   = gathered[15:0];
            entries_pending = gathered[15:0];
            hdr_pos         = '0;
            gathered        = '0;
            hdr_phase       = (entries_pending != 16'd0) ? rfhp_pkg::PH_ENTRY
                                                         : rfhp_pkg::PH_BODY;
            owe_header_part(rfhp_pkg::KIND_ADDRESSING, '0, '0, '0);
          end
        end
        rfhp_pkg::PH_ENTRY: begin
          gathered = gathered | placed;
          if (hdr_pos == 3'd3) begin
            entry_addr_held = gathered;
            gathered        = '0;
          end
          hdr_pos = hdr_pos + 3'd1;
          if (hdr_pos >= 3'd6) begin
            hdr_pos         = '0;
            entries_pending = entries_pending - 16'd1;
            if (entries_pending == 16'd0) hdr_phase = rfhp_pkg::PH_BODY;
            owe_header_part(rfhp_pkg::KIND_ENTRY, entry_addr_held, gathered[15:0], '0);
            gathered = '0;
          end
        end
        rfhp_pkg::PH_BODY: begin
          gathered = gathered | placed;
          hdr_pos  = hdr_pos + 3'd1;
          if (hdr_pos >= 3'd4) begin
            hdr_pos   = '0;
            hdr_phase = rfhp_pkg::PH_DONE;
            owe_header_part(rfhp_pkg::KIND_BODY_LEN, '0, '0, gathered);
            gathered  = '0;
          end
        end
        default: begin
          // idle or finished: byte dropped
        end
      endcase
    end
  endfunction

  // live: the byte takes part in parsing (stray and trailing bytes do not count)
  task automatic push_byte(input logic [7:0] b, input logic st, input logic live);
    frame_bytes_q.push_back({b, st});
    if (live) live_bytes_queued++;
  endtask

  task automatic report_mismatch(input string what, input rfhp_pkg::res_t want,
                                 input rfhp_pkg::res_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %0s", $time, what);
      $display("  expected kind %0d src %02h dst %02h total %04h",
               want.kind, want.source_node, want.dest_node, want.entry_total);
      $display("           addr %08h handle %04h body %08h len %08h",
               want.entry_address, want.entry_handle, want.body_length, want.frame_length);
      $display("  actual   kind %0d src %02h dst %02h total %04h",
               seen.kind, seen.source_node, seen.dest_node, seen.entry_total);
      $display("           addr %08h handle %04h body %08h len %08h",
               seen.entry_address, seen.entry_handle, seen.body_length, seen.frame_length);
    end
  endtask

  // Mostly well-formed frames with random content; the rest are broken on purpose.
  task automatic queue_random_frames(input int unsigned target);
    logic [7:0]  ctrl;
    logic [7:0]  hdr[$];
    logic [31:0] flen;
    logic [31:0] word;
    logic [15:0] count;
    int unsigned base, lf_bytes, flaw, bad_pos, n_entries, keep, i;
    base = live_bytes_queued;
    while (live_bytes_queued - base < target) begin
      hdr.delete();
      ctrl     = 8'($urandom());
      lf_bytes = ctrl[1:0] + 1;
      flaw     = $urandom_range(99);
      // stray bytes: ignored when the parser is idle or done, parsed after a cut frame
      if (flaw < 5) repeat ($urandom_range(1, 4)) push_byte(8'($urandom()), 1'b0, 1'b0);
      flen = $urandom();
      if (lf_bytes < 4) flen = flen & ((32'd1 << (8 * lf_bytes)) - 32'd1);
      if (flaw >= 5 && flaw < 13) flen = $urandom_range(0, 16);
      else if (flen < rfhp_pkg::MIN_FRAME_LENGTH) flen = flen + rfhp_pkg::MIN_FRAME_LENGTH;
      for (i = 0; i < lf_bytes; i++) hdr.push_back(flen[8 * i +: 8]);
      bad_pos = (flaw >= 13 && flaw < 21) ? $urandom_range(0, 6) : 7;
      for (i = 0; i < 7; i++)
        hdr.push_back((i == bad_pos) ? ROUTE_SIG[8 * i +: 8] ^ 8'($urandom_range(1, 255))
                                     : ROUTE_SIG[8 * i +: 8]);
      hdr.push_back(8'($urandom()));
      hdr.push_back(8'($urandom()));
      // large counts are only started, never finished
      if (flaw >= 21 && flaw < 26) begin
        count     = 16'($urandom());
        n_entries = $urandom_range(1, 3);
        if (count < n_entries) count = 16'(n_entries + 1);
      end else begin
        count     = 16'($urandom_range(0, 3));
        n_entries = count;
      end
      hdr.push_back(count[7:0]);
      hdr.push_back(count[15:8]);
      for (i = 0; i < n_entries; i++) begin
        word = $urandom();
        hdr.push_back(word[7:0]);
        hdr.push_back(word[15:8]);
        hdr.push_back(word[23:16]);
        hdr.push_back(word[31:24]);
        word = $urandom();
        hdr.push_back(word[7:0]);
        hdr.push_back(word[15:8]);
      end
      if (n_entries == count) begin
        word = $urandom();
        hdr.push_back(word[7:0]);
        hdr.push_back(word[15:8]);
        hdr.push_back(word[23:16]);
        hdr.push_back(word[31:24]);
      end
      // cut frames are abandoned by the next start
      keep = hdr.size();
      if (flaw >= 26 && flaw < 34) keep = $urandom_range(0, hdr.size() - 1);
      push_byte(ctrl, 1'b1, 1'b1);
      for (i = 0; i < keep; i++) push_byte(hdr[i], 1'b0, 1'b1);
      if (keep == hdr.size())
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom()), 1'b0, 1'b0);
    end
  endtask

  task automatic wait_for_drain();
    while (frame_bytes_q.size() != 0 || in_valid || header_fields_due.size() != 0)
      @(posedge clk);
  endtask

  // Request side: note what was taken at the rising edge, present the next byte at the
  // falling edge. A stalled request is held unchanged.
  always @(posedge clk) begin
    byte_taken = rst_n && in_valid && !in_stall;
    if (byte_taken) parse_header_byte(frame_byte, frame_start);
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || byte_taken)) begin
      if (frame_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = frame_bytes_q.pop_front();
        in_valid    <= 1'b1;
        frame_byte  <= next_byte.data;
        frame_start <= next_byte.start;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Result side: every result taken is checked against the oldest header part owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_fields = {result_kind, source_node, dest_node, entry_total, entry_address,
                     entry_handle, body_length, frame_length};
      if (header_fields_due.size() == 0) begin
        report_mismatch("result with nothing owed", '0, seen_fields);
      end else begin
        want_fields = header_fields_due.pop_front();
        if (seen_fields !== want_fields)
          report_mismatch("result fields differ", want_fields, seen_fields);
      end
    end
  end

  // Hang detection: counts cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles = stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned i;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    frame_byte        = '0;
    frame_start       = 1'b0;
    out_stall         = 1'b0;
    byte_taken        = 1'b0;
    send_idle_pct     = 13;
    recv_idle_pct     = 67;
    live_bytes_queued = 0;
    mismatch_count    = 0;
    stuck_cycles      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames.
    // stray byte while idle: dropped
    push_byte(8'hff, 1'b0, 1'b0);
    // 3-byte length field abandoned by a fresh start after one byte
    push_byte(8'h02, 1'b1, 1'b1);
    push_byte(8'h10, 1'b0, 1'b1);
    // 1-byte length of 16: too short, rejected at once
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'h10, 1'b0, 1'b1);
    // 4-byte length of all ones, signature broken on its second byte
    push_byte(8'hff, 1'b1, 1'b1);
    repeat (4) push_byte(8'hff, 1'b0, 1'b1);
    push_byte(8'h52, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    // shortest legal frame, no entries, body length of all ones, then a trailing byte
    push_byte(8'h01, 1'b1, 1'b1);
    push_byte(8'h11, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    for (i = 0; i < 7; i++) push_byte(ROUTE_SIG[8 * i +: 8], 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hff, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    repeat (4) push_byte(8'hff, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);

    // Random frames in three stretches: slow receiver, slow sender, then flat out.
    queue_random_frames(470);
    wait_for_drain();
    send_idle_pct = 67;
    recv_idle_pct = 13;
    queue_random_frames(470);
    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_frames(470);
    wait_for_drain();

    // let the bench idle so that any stray late result is caught
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && header_fields_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
